### src/jse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jse_pkg: shared types and constants for the JSON string escaper
// Word formats for both channels, escape classes and the byte lookups.
// ----------------------------------------------------------------------------
package jse_pkg;

  // Operation codes on the input channel
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Escape classes of one raw byte
  localparam logic [1:0] CLS_PASS  = 2'd0;  // copied unchanged
  localparam logic [1:0] CLS_SHORT = 2'd1;  // backslash + one letter
  localparam logic [1:0] CLS_UHEX  = 2'd2;  // \u00 + two hex digits

  // Character constants
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_A         = 8'h61;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       string_closed;
  } result_t;

  // Escape class of a raw byte
  function automatic logic [1:0] esc_class(input logic [7:0] c);
    logic [1:0] cls;
    cls = CLS_PASS;
    if (c >= 8'h07 && c <= 8'h0D)
      cls = CLS_SHORT;
    else if (c < 8'h20 || c == 8'h7F || c == 8'hC0 || c == 8'hC1 || c >= 8'hF5)
      cls = CLS_UHEX;
    else if (c == CH_QUOTE || c == CH_BACKSLASH)
      cls = CLS_SHORT;
    return cls;
  endfunction

  // Letter after the backslash for the short escapes
  function automatic logic [7:0] esc_letter(input logic [7:0] c);
    logic [7:0] l;
    unique case (c)
      8'h07:   l = 8'h61;  // a
      8'h08:   l = 8'h62;  // b
      8'h09:   l = 8'h74;  // t
      8'h0A:   l = 8'h6E;  // n
      8'h0B:   l = 8'h76;  // v
      8'h0C:   l = 8'h66;  // f
      8'h0D:   l = 8'h72;  // r
      default: l = c;      // quote and backslash stand for themselves
    endcase
    return l;
  endfunction

  // Lowercase hex digit of one nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    if (n < 4'd10)
      d = CH_ZERO + {4'd0, n};
    else
      d = CH_A + {4'd0, n} - 8'd10;
    return d;
  endfunction

endpackage
`default_nettype wire

### src/json_string_escaper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_escaper: streams raw bytes into a quoted JSON-style string literal
// Each input word is held in an item register and played out one escaped
// byte per cycle, while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
// The first result byte of a word passes the item register, then the output register.
// Throughput: an input word yields 1 to 7 result bytes at one byte per cycle
//   while result_ready holds, so plain characters inside an open string run at
//   one word per cycle; the single item register playing out its bytes sets the rate.
// Reset: synchronous, clears the item and output valids and closes the string.
module json_string_escaper (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   item_valid,
  output logic                  item_ready,
  input  wire jse_pkg::item_t   item,
  output logic                  result_valid,
  input  wire                   result_ready,
  output jse_pkg::result_t      result
);

  // Item register and play-out state
  logic           seq_valid;
  jse_pkg::item_t seq_item;
  logic           seq_open;     // opening quote still owed for this word
  logic [2:0]     idx;
  logic           inside_string;

  // Byte generation for the current index
  logic [1:0]       cls;
  logic [2:0]       count;
  logic [2:0]       body_idx;
  logic             gen_last;
  logic             load;
  jse_pkg::result_t gen;

  always_comb begin
    cls = jse_pkg::esc_class(seq_item.char_byte);
    if (seq_item.operation == jse_pkg::OP_END)
      count = 3'd1;
    else begin
      unique case (cls)
        jse_pkg::CLS_SHORT: count = 3'd2;
        jse_pkg::CLS_UHEX:  count = 3'd6;
        default:            count = 3'd1;
      endcase
    end
    count    = count + {2'd0, seq_open};
    body_idx = idx - {2'd0, seq_open};
    gen_last = (idx == count - 3'd1);

    gen.last          = gen_last;
    gen.string_closed = 1'b0;
    gen.out_byte      = seq_item.char_byte;
    if (seq_open && idx == 3'd0)
      gen.out_byte = jse_pkg::CH_QUOTE;
    else if (seq_item.operation == jse_pkg::OP_END) begin
      gen.out_byte      = jse_pkg::CH_QUOTE;
      gen.string_closed = 1'b1;
    end else if (cls == jse_pkg::CLS_SHORT) begin
      gen.out_byte = (body_idx == 3'd0) ? jse_pkg::CH_BACKSLASH
                                        : jse_pkg::esc_letter(seq_item.char_byte);
    end else if (cls == jse_pkg::CLS_UHEX) begin
      unique case (body_idx)
        3'd0:    gen.out_byte = jse_pkg::CH_BACKSLASH;
        3'd1:    gen.out_byte = jse_pkg::CH_U;
        3'd2:    gen.out_byte = jse_pkg::CH_ZERO;
        3'd3:    gen.out_byte = jse_pkg::CH_ZERO;
        3'd4:    gen.out_byte = jse_pkg::hex_digit(seq_item.char_byte[7:4]);
        default: gen.out_byte = jse_pkg::hex_digit(seq_item.char_byte[3:0]);
      endcase
    end
  end

  // Handshake: move a byte when the output register is free or draining
  assign load       = seq_valid && (!result_valid || result_ready);
  assign item_ready = !seq_valid || (load && gen_last);

  // Item register, index and string state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_valid     <= 1'b0;
      idx           <= 3'd0;
      inside_string <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        seq_valid     <= 1'b1;
        idx           <= 3'd0;
        inside_string <= (item.operation == jse_pkg::OP_CHAR);
      end else if (load) begin
        seq_valid <= !gen_last;
        idx       <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      seq_item <= item;
      seq_open <= !inside_string;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)
      result_valid <= 1'b0;
    else if (load)
      result_valid <= 1'b1;
    else if (result_ready)
      result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load)
      result <= gen;
  end

`ifndef SYNTHESIS
  // The index never runs past the word's byte count
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    seq_valid |-> idx < count)
    else $error("index past byte count");

  // A closing quote is always the final byte of its word
  a_close_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.string_closed) |->
      (result.last && result.out_byte == jse_pkg::CH_QUOTE))
    else $error("closing quote not last or not a quote");

  // An end marker leaves the string closed
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.operation == jse_pkg::OP_END)
      |=> !inside_string)
    else $error("string left open after end marker");

  // Nothing is shown right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !seq_valid)
    else $error("valid after reset");
`endif

endmodule
`default_nettype wire
